>>> design/ray_segment_radiance_accumulator_macros.svh
// Assertion macros for the ray segment radiance accumulator.
`ifndef RAY_SEGMENT_RADIANCE_ACCUMULATOR_MACROS_SVH
`define RAY_SEGMENT_RADIANCE_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rsra_pkg.sv
// Shared constants, microcode types and the control store of the radiance accumulator.
`timescale 1ns / 1ps

package rsra_pkg;

  localparam int EXP_TABLE_BITS = 10;
  localparam int TAB_SIZE       = 1 << EXP_TABLE_BITS;
  localparam int TAB_AW         = EXP_TABLE_BITS;
  localparam int TAB_LSB        = 24 - EXP_TABLE_BITS;
  localparam int TAY_SH         = EXP_TABLE_BITS - 4;

  localparam logic [16:0] ONE_Q16      = 17'h1_0000;
  localparam logic [22:0] SIGMA_PI_Q48 = 23'd5080444;
  localparam logic [63:0] HALF_Q16     = 64'h0000_0000_0000_8000;
  localparam logic [63:0] HALF_Q32     = 64'h0000_0000_8000_0000;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;

  // exp(-2^(4-EXP_TABLE_BITS)) in Q0.32, alternating Taylor sum of 13 terms
  function automatic logic [63:0] exp_ratio_calc();
    logic [63:0] term;
    logic [63:0] acc;
    term = 64'h0000_0001_0000_0000;
    acc  = term;
    term = (term >> TAY_SH) / 1;
    acc  = acc - term;
    term = (term >> TAY_SH) / 2;
    acc  = acc + term;
    term = (term >> TAY_SH) / 3;
    acc  = acc - term;
    term = (term >> TAY_SH) / 4;
    acc  = acc + term;
    term = (term >> TAY_SH) / 5;
    acc  = acc - term;
    term = (term >> TAY_SH) / 6;
    acc  = acc + term;
    term = (term >> TAY_SH) / 7;
    acc  = acc - term;
    term = (term >> TAY_SH) / 8;
    acc  = acc + term;
    term = (term >> TAY_SH) / 9;
    acc  = acc - term;
    term = (term >> TAY_SH) / 10;
    acc  = acc + term;
    term = (term >> TAY_SH) / 11;
    acc  = acc - term;
    term = (term >> TAY_SH) / 12;
    acc  = acc + term;
    return acc;
  endfunction

  localparam logic [63:0] EXP_RATIO = exp_ratio_calc();

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_SQ     = 4'd1;
  localparam pc_t PC_P4     = 4'd2;
  localparam pc_t PC_X      = 4'd3;
  localparam pc_t PC_LO     = 4'd4;
  localparam pc_t PC_HI     = 4'd5;
  localparam pc_t PC_BB     = 4'd6;
  localparam pc_t PC_EMIT   = 4'd7;
  localparam pc_t PC_ADD    = 4'd8;
  localparam pc_t PC_COMMIT = 4'd9;
  localparam pc_t PC_FILL   = 4'd10;

  typedef enum logic [3:0] {
    A_TEMP, A_SQ, A_KAPPA, A_PLO, A_PHI, A_TRANS, A_BB, A_EMIT, A_EFILL
  } asel_t;

  typedef enum logic [2:0] {
    B_TEMP, B_SQ, B_PATH, B_SIGMA, B_GFAC, B_FFAC, B_TRANS, B_RATIO
  } bsel_t;

  typedef enum logic [1:0] {
    C_NEVER, C_NO_INPUT, C_OUT_BUSY, C_FILL_MORE
  } cond_t;

  typedef struct packed {
    asel_t a_sel;
    bsel_t b_sel;
    logic  ld_in;
    logic  ld_p;
    logic  rd_tab;
    logic  ld_lo;
    logic  ld_e;
    logic  ld_bb;
    logic  ld_tnew;
    logic  commit;
    logic  fill_wr;
    cond_t cond;
    pc_t   jmp_pc;
    pc_t   seq_pc;
  } uc_t;

  typedef struct packed {
    logic out_busy;
    logic fill_more;
  } stat_t;

  function automatic uc_t ucode(pc_t pc);
    uc_t w;
    w        = '0;
    w.a_sel  = A_TEMP;
    w.b_sel  = B_TEMP;
    w.cond   = C_NEVER;
    w.jmp_pc = PC_IDLE;
    w.seq_pc = PC_IDLE;
    unique case (pc)
      PC_IDLE: begin
        w.ld_in  = 1'b1;
        w.cond   = C_NO_INPUT;
        w.jmp_pc = PC_IDLE;
        w.seq_pc = PC_SQ;
      end
      PC_SQ: begin
        w.a_sel  = A_TEMP;
        w.b_sel  = B_TEMP;
        w.seq_pc = PC_P4;
      end
      PC_P4: begin
        w.a_sel  = A_SQ;
        w.b_sel  = B_SQ;
        w.seq_pc = PC_X;
      end
      PC_X: begin
        w.ld_p   = 1'b1;
        w.a_sel  = A_KAPPA;
        w.b_sel  = B_PATH;
        w.seq_pc = PC_LO;
      end
      PC_LO: begin
        w.rd_tab = 1'b1;
        w.a_sel  = A_PLO;
        w.b_sel  = B_SIGMA;
        w.seq_pc = PC_HI;
      end
      PC_HI: begin
        w.ld_lo  = 1'b1;
        w.ld_e   = 1'b1;
        w.a_sel  = A_PHI;
        w.b_sel  = B_SIGMA;
        w.seq_pc = PC_BB;
      end
      PC_BB: begin
        w.ld_bb  = 1'b1;
        w.a_sel  = A_TRANS;
        w.b_sel  = B_GFAC;
        w.seq_pc = PC_EMIT;
      end
      PC_EMIT: begin
        w.ld_tnew = 1'b1;
        w.a_sel   = A_BB;
        w.b_sel   = B_FFAC;
        w.seq_pc  = PC_ADD;
      end
      PC_ADD: begin
        w.a_sel  = A_EMIT;
        w.b_sel  = B_TRANS;
        w.seq_pc = PC_COMMIT;
      end
      PC_COMMIT: begin
        w.commit = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.jmp_pc = PC_COMMIT;
        w.seq_pc = PC_IDLE;
      end
      PC_FILL: begin
        w.fill_wr = 1'b1;
        w.a_sel   = A_EFILL;
        w.b_sel   = B_RATIO;
        w.cond    = C_FILL_MORE;
        w.jmp_pc  = PC_FILL;
        w.seq_pc  = PC_IDLE;
      end
      default: begin
        w.seq_pc = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> design/rsra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsra_ram #(
  parameter int   WIDTH = 17,
  parameter int   DEPTH = 1024,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/rsra_useq.sv
// Microcode sequencer: step counter, control store fetch and conditional jumps.
`timescale 1ns / 1ps

module rsra_useq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rsra_pkg::stat_t      st,
  output rsra_pkg::uc_t        uc
);

  rsra_pkg::pc_t pc_r;
  rsra_pkg::pc_t pc_nxt;
  logic          take_jmp;

  assign uc = rsra_pkg::ucode(pc_r);

  always_comb begin
    unique case (uc.cond)
      rsra_pkg::C_NEVER:     take_jmp = 1'b0;
      rsra_pkg::C_NO_INPUT:  take_jmp = ~in_valid;
      rsra_pkg::C_OUT_BUSY:  take_jmp = st.out_busy;
      rsra_pkg::C_FILL_MORE: take_jmp = st.fill_more;
    endcase
    pc_nxt = take_jmp ? uc.jmp_pc : uc.seq_pc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rsra_pkg::PC_FILL;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> design/rsra_dp.sv
// Datapath: shared multiplier, operand muxes, accumulators, exp table and result register.
`timescale 1ns / 1ps

module rsra_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsra_pkg::uc_t        uc,
  output rsra_pkg::stat_t      st,
  input  logic                 in_valid,
  input  logic [15:0]          in_absorption_coeff,
  input  logic [15:0]          in_cell_temp,
  input  logic [15:0]          in_path_len,
  input  logic                 in_is_boundary,
  input  logic                 in_last_segment,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_ray_intensity,
  output logic [16:0]          out_ray_transmittance
);

  logic [15:0] kappa_r;
  logic [15:0] temp_r;
  logic [15:0] path_r;
  logic        bnd_r;
  logic        last_r;

  logic [63:0] prod_r;
  logic [39:0] p_r;
  logic [38:0] lo_r;
  logic        ovf_r;
  logic [16:0] e_r;
  logic [31:0] bb_r;
  logic [16:0] tnew_r;

  logic [31:0] acc_int_r;
  logic [16:0] acc_tr_r;
  logic        out_valid_r;
  logic [31:0] out_int_r;
  logic [16:0] out_tr_r;

  logic [rsra_pkg::TAB_AW-1:0] fill_cnt_r;
  logic [32:0]                 efill_r;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_full;
  logic [63:0] mul_p;
  logic [63:0] prod_rnd;
  logic [31:0] emit;
  logic [16:0] gfac;
  logic [16:0] ffac;
  logic [63:0] bb_sum;
  logic [63:0] ef_sum;
  logic [32:0] efill_nxt;
  logic [32:0] ef_rnd;
  logic [16:0] tab_q;
  logic [33:0] acc_sum;
  logic [31:0] acc_int_nxt;
  logic        accept;
  logic        commit_en;
  logic        out_busy;

  assign accept    = in_valid & uc.ld_in;
  assign out_busy  = last_r & out_valid_r & out_stall;
  assign commit_en = uc.commit & ~out_busy;

  assign st.out_busy  = out_busy;
  assign st.fill_more = (fill_cnt_r != '1);

  assign prod_rnd = prod_r + rsra_pkg::HALF_Q16;
  assign emit     = prod_rnd[47:16];
  assign gfac     = bnd_r ? rsra_pkg::ONE_Q16 : e_r;
  assign ffac     = bnd_r ? rsra_pkg::ONE_Q16 : (rsra_pkg::ONE_Q16 - e_r);

  always_comb begin
    unique case (uc.a_sel)
      rsra_pkg::A_TEMP:  mul_a = {17'd0, temp_r};
      rsra_pkg::A_SQ:    mul_a = {1'b0, prod_r[31:0]};
      rsra_pkg::A_KAPPA: mul_a = {17'd0, kappa_r};
      rsra_pkg::A_PLO:   mul_a = {17'd0, p_r[15:0]};
      rsra_pkg::A_PHI:   mul_a = {9'd0, p_r[39:16]};
      rsra_pkg::A_TRANS: mul_a = {16'd0, acc_tr_r};
      rsra_pkg::A_BB:    mul_a = {1'b0, bb_r};
      rsra_pkg::A_EMIT:  mul_a = {1'b0, emit};
      rsra_pkg::A_EFILL: mul_a = efill_r;
      default:           mul_a = '0;
    endcase
    unique case (uc.b_sel)
      rsra_pkg::B_TEMP:  mul_b = {16'd0, temp_r};
      rsra_pkg::B_SQ:    mul_b = prod_r[31:0];
      rsra_pkg::B_PATH:  mul_b = {16'd0, path_r};
      rsra_pkg::B_SIGMA: mul_b = {9'd0, rsra_pkg::SIGMA_PI_Q48};
      rsra_pkg::B_GFAC:  mul_b = {15'd0, gfac};
      rsra_pkg::B_FFAC:  mul_b = {15'd0, ffac};
      rsra_pkg::B_TRANS: mul_b = {15'd0, acc_tr_r};
      rsra_pkg::B_RATIO: mul_b = rsra_pkg::EXP_RATIO[31:0];
    endcase
  end

  assign mul_full = {32'd0, mul_a} * {33'd0, mul_b};
  assign mul_p    = mul_full[63:0];

  // black body: (p_hi*S << 16) + p_lo*S, rounded at bit 32
  assign bb_sum = {prod_r[47:0], 16'd0} + {25'd0, lo_r} + rsra_pkg::HALF_Q32;

  assign ef_sum    = mul_p + rsra_pkg::HALF_Q32;
  assign efill_nxt = {1'b0, ef_sum[63:32]};
  assign ef_rnd    = efill_r + 33'h0_0000_8000;

  assign acc_sum     = {2'b00, acc_int_r} + {1'b0, prod_rnd[48:16]};
  assign acc_int_nxt = (acc_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : acc_sum[31:0];

  rsra_ram #(
    .WIDTH (17),
    .DEPTH (rsra_pkg::TAB_SIZE)
  ) u_exp_tab (
    .clk   (clk),
    .we    (uc.fill_wr),
    .waddr (fill_cnt_r),
    .wdata (ef_rnd[32:16]),
    .raddr (prod_r[23:rsra_pkg::TAB_LSB]),
    .rdata (tab_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_int_r   <= '0;
      acc_tr_r    <= rsra_pkg::ONE_Q16;
      out_valid_r <= 1'b0;
      fill_cnt_r  <= '0;
      efill_r     <= rsra_pkg::ONE_Q32;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (uc.fill_wr) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
        efill_r    <= efill_nxt;
      end
      if (commit_en) begin
        if (last_r) begin
          out_valid_r <= 1'b1;
          acc_int_r   <= '0;
          acc_tr_r    <= rsra_pkg::ONE_Q16;
        end else begin
          acc_int_r <= acc_int_nxt;
          acc_tr_r  <= tnew_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    // the commit step may wait on the output; keep the final product meanwhile
    if (!uc.commit) begin
      prod_r <= mul_p;
    end
    if (accept) begin
      kappa_r <= in_absorption_coeff;
      temp_r  <= in_cell_temp;
      path_r  <= in_path_len;
      bnd_r   <= in_is_boundary;
      last_r  <= in_last_segment;
    end
    if (uc.ld_p) begin
      p_r <= prod_r[63:24];
    end
    if (uc.rd_tab) begin
      ovf_r <= |prod_r[31:24];
    end
    if (uc.ld_lo) begin
      lo_r <= prod_r[38:0];
    end
    if (uc.ld_e) begin
      e_r <= ovf_r ? 17'd0 : tab_q;
    end
    if (uc.ld_bb) begin
      bb_r <= bb_sum[63:32];
    end
    if (uc.ld_tnew) begin
      tnew_r <= prod_rnd[32:16];
    end
    if (commit_en && last_r) begin
      out_int_r <= acc_int_nxt;
      out_tr_r  <= tnew_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_ray_intensity     = out_int_r;
  assign out_ray_transmittance = out_tr_r;

endmodule

>>> design/ray_segment_radiance_accumulator.sv
// Top level of the ray segment radiance accumulator: sequencer, datapath and checks.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   absorption_coeff, cell_temp, path_len,
//                                           is_boundary, last_segment
//   out_     output     out_valid/out_stall ray_intensity, ray_transmittance
//
// One item runs through the accept step plus nine microcode steps, set by the
// eight products that go one per cycle through the shared 33x32 multiplier.
// After reset the exp table is filled, one entry a cycle, all TAB_SIZE (1024)
// entries with in_stall high. A last segment holds its commit step while the
// previous result still waits on out_stall, until the output register is free.
`timescale 1ns / 1ps
`include "ray_segment_radiance_accumulator_macros.svh"

module ray_segment_radiance_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_absorption_coeff,
  input  logic [15:0] in_cell_temp,
  input  logic [15:0] in_path_len,
  input  logic        in_is_boundary,
  input  logic        in_last_segment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_ray_intensity,
  output logic [16:0] out_ray_transmittance
);

  rsra_pkg::uc_t   uc;
  rsra_pkg::stat_t st;

  assign in_stall = ~uc.ld_in;

  rsra_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .uc       (uc)
  );

  rsra_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .uc                    (uc),
    .st                    (st),
    .in_valid              (in_valid),
    .in_absorption_coeff   (in_absorption_coeff),
    .in_cell_temp          (in_cell_temp),
    .in_path_len           (in_path_len),
    .in_is_boundary        (in_is_boundary),
    .in_last_segment       (in_last_segment),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_ray_intensity     (out_ray_intensity),
    .out_ray_transmittance (out_ray_transmittance)
  );

  `RSRA_ASSERT_IMP(a_fill_blocks_input, uc.fill_wr, in_stall, "item taken during table fill")
  `RSRA_ASSERT_IMP(a_out_from_commit, $rose(out_valid), $past(uc.commit), "result without commit")
  `RSRA_ASSERT_NXT(a_commit_to_idle, uc.commit && !st.out_busy, uc.ld_in, "commit not followed by idle")
  `RSRA_ASSERT_IMP(a_trans_range, out_valid, out_ray_transmittance <= rsra_pkg::ONE_Q16, "transmittance above one")

endmodule
